### design/xmac_pkg.sv
// shared types and constants for the x-mac low power listening controller
// no dependencies; imported by every module of the block

package xmac_pkg;

  // fixed field widths, tag width included
  localparam int TagW    = 8;
  localparam int ApbAddrW = 5;
  localparam int ApbDataW = 32;
  localparam int InDataW  = 64;
  localparam int OutDataW = 88;

  // event codes carried in s_tuser
  localparam logic [2:0] CmdSend    = 3'd0;
  localparam logic [2:0] CmdBackoff = 3'd1;
  localparam logic [2:0] CmdWakeup  = 3'd2;
  localparam logic [2:0] CmdStrobe  = 3'd3;
  localparam logic [2:0] CmdSleep   = 3'd4;
  localparam logic [2:0] CmdRx      = 3'd5;
  localparam logic [2:0] CmdStop    = 3'd6;

  // received packet kinds
  localparam logic [1:0] KindStrobe   = 2'd0;
  localparam logic [1:0] KindEarlyAck = 2'd1;

  // mac states
  localparam logic [2:0] StDisabled    = 3'd0;
  localparam logic [2:0] StSleep       = 3'd1;
  localparam logic [2:0] StListen      = 3'd2;
  localparam logic [2:0] StStrobe      = 3'd3;
  localparam logic [2:0] StData        = 3'd4;
  localparam logic [2:0] StCheckStrobe = 3'd6;

  // radio commands
  localparam logic [2:0] RadioNone   = 3'd0;
  localparam logic [2:0] RadioWake   = 3'd1;
  localparam logic [2:0] RadioSleep  = 3'd2;
  localparam logic [2:0] RadioStrobe = 3'd3;
  localparam logic [2:0] RadioData   = 3'd4;
  localparam logic [2:0] RadioAck    = 3'd5;

  // completion kinds
  localparam logic [1:0] DoneNone    = 2'd0;
  localparam logic [1:0] DoneSent    = 2'd1;
  localparam logic [1:0] DoneDropped = 2'd2;

  // timer bits
  localparam logic [3:0] TmrBackoff = 4'b0001;
  localparam logic [3:0] TmrWake    = 4'b0010;
  localparam logic [3:0] TmrStrobe  = 4'b0100;
  localparam logic [3:0] TmrSleep   = 4'b1000;
  localparam logic [3:0] TmrAll     = 4'b1111;

  localparam logic [15:0] BcastAddr  = 16'h00ff;
  localparam logic [9:0]  MaskCap    = 10'h3ff;
  localparam logic [3:0]  MaskCapExp = 4'd10;

  // register indexes
  localparam logic [2:0] RegNodeAddr   = 3'd0;
  localparam logic [2:0] RegPreamble   = 3'd1;
  localparam logic [2:0] RegMaxRetries = 3'd2;
  localparam logic [2:0] RegQueueLimit = 3'd3;
  localparam logic [2:0] RegMinBackoff = 3'd4;

  // register reset values
  localparam logic [15:0] RstNodeAddr   = 16'd0;
  localparam logic [15:0] RstPreamble   = 16'd51;
  localparam logic [3:0]  RstMaxRetries = 4'd7;
  localparam logic [5:0]  RstQueueLimit = 6'd30;
  localparam logic [9:0]  RstMinBackoff = 10'd2;

  typedef struct packed {
    logic [15:0] own_addr;
    logic [15:0] preamble_limit;
    logic [3:0]  retry_limit;
    logic [5:0]  queue_limit;
    logic [9:0]  min_backoff;
  } cfg_t;

  // input transfer payload, declared msb first
  typedef struct packed {
    logic [15:0]     random_value;
    logic [15:0]     rx_src_addr;
    logic [15:0]     rx_dest_addr;
    logic [1:0]      rx_packet_kind;
    logic            rx_valid;
    logic            preamble_detected;
    logic            channel_clear;
    logic [TagW-1:0] message_tag;
  } in_item_t;

  // result payload, declared msb first
  typedef struct packed {
    logic [2:0]      radio_state;
    logic            deliver_received;
    logic [15:0]     backoff_delay;
    logic [3:0]      timer_stop_mask;
    logic [3:0]      timer_restart_mask;
    logic [TagW-1:0] done_tag;
    logic [1:0]      done_kind;
    logic [15:0]     ack_dest_addr;
    logic [15:0]     tx_sequence;
    logic [TagW-1:0] tx_message_tag;
    logic [2:0]      radio_command;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctrl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

### design/xmac_cfg_regs.sv
// apb configuration registers of the x-mac controller
// depends on xmac_pkg for the register indexes and cfg_t

module xmac_cfg_regs import xmac_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t        cfg_q, cfg_d;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegNodeAddr:   cfg_d.own_addr       = pwdata[15:0];
        RegPreamble:   cfg_d.preamble_limit = pwdata[15:0];
        RegMaxRetries: cfg_d.retry_limit    = pwdata[3:0];
        RegQueueLimit: cfg_d.queue_limit    = pwdata[5:0];
        RegMinBackoff: cfg_d.min_backoff    = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegNodeAddr:   prdata = ApbDataW'(cfg_q.own_addr);
      RegPreamble:   prdata = ApbDataW'(cfg_q.preamble_limit);
      RegMaxRetries: prdata = ApbDataW'(cfg_q.retry_limit);
      RegQueueLimit: prdata = ApbDataW'(cfg_q.queue_limit);
      RegMinBackoff: prdata = ApbDataW'(cfg_q.min_backoff);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_addr       <= RstNodeAddr;
      cfg_q.preamble_limit <= RstPreamble;
      cfg_q.retry_limit    <= RstMaxRetries;
      cfg_q.queue_limit    <= RstQueueLimit;
      cfg_q.min_backoff    <= RstMinBackoff;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/xmac_tag_fifo.sv
// circular queue of pending message tags with a registered head read
// depends on xmac_pkg for the fifo control and status structs

module xmac_tag_fifo import xmac_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int TW    = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fifo_ctrl_t    ctrl_i,
  input  logic [TW-1:0] wdata_i,
  input  logic [5:0]    queue_limit_i,
  output fifo_stat_t    stat_o,
  output logic [TW-1:0] head_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SumW = CntW + 1;
  localparam int LimW = (CntW > 6) ? CntW : 6;

  logic [TW-1:0]   mem [DEPTH];
  logic [TW-1:0]   head_data_q;
  logic [PtrW-1:0] head_q, head_d, wr_ptr;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] wr_sum;

  assign wr_sum = SumW'(head_q) + SumW'(count_q);
  assign wr_ptr = (wr_sum >= SumW'(DEPTH)) ? PtrW'(wr_sum - SumW'(DEPTH)) : PtrW'(wr_sum);

  always_comb begin
    head_d = head_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == PtrW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl_i.push && !ctrl_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (ctrl_i.pop && !ctrl_i.push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  // head_data_q always mirrors the entry at head_q, forwarding a write to it
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[wr_ptr] <= wdata_i;
    end
    if (ctrl_i.push && (wr_ptr == head_d)) begin
      head_data_q <= wdata_i;
    end else begin
      head_data_q <= mem[head_d];
    end
  end

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (LimW'(count_q) >= LimW'(queue_limit_i)) ||
                        (count_q == CntW'(DEPTH));
  assign head_o       = head_data_q;

endmodule

### design/xmac_core.sv
// event decision logic and protocol state of the x-mac controller
// depends on xmac_pkg; drives the tag fifo through fifo_ctrl_t

module xmac_core import xmac_pkg::*; #(
  parameter int TW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [2:0]    cmd_i,
  input  in_item_t      item_i,
  input  cfg_t          cfg_i,
  input  fifo_stat_t    fifo_stat_i,
  input  logic [TW-1:0] fifo_head_i,
  output fifo_ctrl_t    fifo_ctrl_o,
  output logic [TW-1:0] fifo_wdata_o,
  output res_t          res_o
);

  logic [2:0]    ms_q, ms_d;
  logic [15:0]   sc_q, sc_d;
  logic [15:0]   seq_q, seq_d;
  logic [3:0]    retry_q, retry_d;
  logic [TW-1:0] ctag_q, ctag_d;
  logic          cval_q, cval_d;

  logic          do_sod, sod_rs;
  logic [TW-1:0] sod_tag, in_tag;
  logic [3:0]    restart, stop;
  logic [9:0]    bo_mask;
  logic          push, pop;
  res_t          r;

  assign in_tag = item_i.message_tag[TW-1:0];

  always_comb begin
    ms_d    = ms_q;
    sc_d    = sc_q;
    seq_d   = seq_q;
    retry_d = retry_q;
    ctag_d  = ctag_q;
    cval_d  = cval_q;
    do_sod  = 1'b0;
    sod_rs  = 1'b0;
    sod_tag = ctag_q;
    restart = '0;
    stop    = '0;
    push    = 1'b0;
    pop     = 1'b0;
    r       = '0;
    r.radio_command = RadioNone;
    r.done_kind     = DoneNone;

    unique case (cmd_i)
      CmdSend: begin
        seq_d = seq_q + 1'b1;
        if (item_i.channel_clear && !cval_q) begin
          do_sod  = 1'b1;
          sod_rs  = 1'b1;
          sod_tag = in_tag;
        end else begin
          if (!fifo_stat_i.full) begin
            push = 1'b1;
          end else begin
            r.done_kind = DoneDropped;
            r.done_tag  = TagW'(in_tag);
          end
          restart = restart | TmrBackoff;
        end
      end
      CmdBackoff: begin
        if (!fifo_stat_i.empty) begin
          if (item_i.channel_clear && !cval_q) begin
            pop     = 1'b1;
            do_sod  = 1'b1;
            sod_rs  = 1'b1;
            sod_tag = fifo_head_i;
            retry_d = '0;
          end else if (retry_q < cfg_i.retry_limit) begin
            retry_d = retry_q + 1'b1;
          end else begin
            r.done_kind = DoneDropped;
            r.done_tag  = TagW'(fifo_head_i);
            pop         = 1'b1;
            retry_d     = '0;
          end
          restart = restart | TmrBackoff;
        end
      end
      CmdWakeup: begin
        stop            = TmrWake;
        restart         = TmrSleep;
        r.radio_command = RadioWake;
        ms_d            = StListen;
      end
      CmdStrobe: begin
        if (cval_q) begin
          do_sod = 1'b1;
          ms_d   = StStrobe;
        end
      end
      CmdSleep: begin
        if (!item_i.preamble_detected) begin
          r.radio_command = RadioSleep;
          ms_d            = StSleep;
          restart         = TmrWake;
        end
      end
      CmdRx: begin
        stop = TmrSleep;
        if (item_i.rx_valid) begin
          if (item_i.rx_packet_kind == KindStrobe) begin
            ms_d = StCheckStrobe;
            if (item_i.rx_dest_addr == cfg_i.own_addr) begin
              r.radio_command = RadioAck;
              r.ack_dest_addr = item_i.rx_src_addr;
              ms_d            = StListen;
            end else if (item_i.rx_dest_addr != BcastAddr) begin
              ms_d = StListen;
              if (!item_i.preamble_detected) begin
                r.radio_command = RadioSleep;
                ms_d            = StSleep;
                restart         = TmrWake;
              end
            end
          end else if (item_i.rx_packet_kind == KindEarlyAck) begin
            if (cval_q) begin
              // early ack cuts the strobe train short
              stop             = TmrStrobe;
              restart          = TmrSleep;
              r.radio_command  = RadioData;
              r.tx_message_tag = TagW'(ctag_q);
              r.tx_sequence    = seq_q;
              r.done_kind      = DoneSent;
              r.done_tag       = TagW'(ctag_q);
              ms_d             = StListen;
              cval_d           = 1'b0;
              sc_d             = '0;
            end else begin
              stop = TmrSleep | TmrStrobe;
            end
          end else begin
            r.deliver_received = 1'b1;
            ms_d               = StListen;
            stop               = '0;
            restart            = TmrSleep;
          end
        end
      end
      CmdStop: begin
        ms_d            = StDisabled;
        stop            = TmrAll;
        r.radio_command = RadioSleep;
      end
      default: ;
    endcase

    // strobe or data for the message now current
    if (do_sod) begin
      ctag_d = sod_tag;
      cval_d = 1'b1;
      if (sc_q < cfg_i.preamble_limit) begin
        r.radio_command  = RadioStrobe;
        r.tx_message_tag = TagW'(sod_tag);
        r.tx_sequence    = seq_d;
        sc_d             = sc_q + 1'b1;
        ms_d             = StListen;
        stop             = stop | TmrSleep;
        if (sod_rs) begin
          restart = restart | TmrStrobe;
        end
      end else begin
        sc_d             = '0;
        r.radio_command  = RadioData;
        r.tx_message_tag = TagW'(sod_tag);
        r.tx_sequence    = seq_d;
        r.done_kind      = DoneSent;
        r.done_tag       = TagW'(sod_tag);
        ms_d             = StListen;
        cval_d           = 1'b0;
        stop             = stop | TmrStrobe;
        restart          = restart | TmrSleep;
      end
    end

    r.timer_restart_mask = restart;
    r.timer_stop_mask    = stop;
    r.radio_state        = ms_d;
  end

  // backoff window grows with the retry count left by this event
  assign bo_mask = (retry_d >= MaskCapExp) ? MaskCap : 10'((11'd1 << retry_d) - 11'd1);

  always_comb begin
    res_o = r;
    if (restart[0]) begin
      res_o.backoff_delay = 16'(item_i.random_value[9:0] & bo_mask) +
                            16'(cfg_i.min_backoff);
    end
  end

  assign fifo_ctrl_o.push = fire_i & push;
  assign fifo_ctrl_o.pop  = fire_i & pop;
  assign fifo_wdata_o     = in_tag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q    <= StListen;
      sc_q    <= '0;
      seq_q   <= '0;
      retry_q <= '0;
      ctag_q  <= '0;
      cval_q  <= 1'b0;
    end else if (fire_i) begin
      ms_q    <= ms_d;
      sc_q    <= sc_d;
      seq_q   <= seq_d;
      retry_q <= retry_d;
      ctag_q  <= ctag_d;
      cval_q  <= cval_d;
    end
  end

endmodule

### design/xmac_low_power_mac_controller.sv
// x-mac low power listening controller: stream top level with apb configuration
// depends on xmac_pkg, xmac_cfg_regs, xmac_tag_fifo and xmac_core
//
// usage:
//   slave stream carries one event per transfer; s_tuser holds the event code,
//   s_tdata the event fields. master stream returns exactly one result per event.
//   the apb port sets node address, preamble limit, retries, queue limit and
//   minimum backoff; write it only while no event is in flight.
// timing:
//   an event taken from the slave stream sits in the input register, is decided
//   combinationally and lands in the result register, which drives m_tvalid and
//   m_tdata. one event per cycle is sustained while m_tready is high; the
//   decision logic and the tag queue's registered head read both keep up every cycle.
// stalls and reset:
//   with m_tready low the result holds and the input register still takes one
//   more event; s_tready drops only when both registers are full.
//   reset puts the mac in listen with no message in flight and an empty queue;
//   registers return to their defaults.

module xmac_low_power_mac_controller import xmac_pkg::*; #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // fields from bit 0: message_tag[7:0], channel_clear, preamble_detected,
  // rx_valid, rx_packet_kind[1:0], rx_dest_addr[15:0], rx_src_addr[15:0],
  // random_value[15:0], zero fill
  input  logic [InDataW-1:0]  s_tdata,
  // fields from bit 0: command[2:0]
  input  logic [2:0]          s_tuser,
  input  logic                s_tvalid,
  output logic                s_tready,
  // fields from bit 0: radio_command[2:0], tx_message_tag[7:0], tx_sequence[15:0],
  // ack_dest_addr[15:0], done_kind[1:0], done_tag[7:0], timer_restart_mask[3:0],
  // timer_stop_mask[3:0], backoff_delay[15:0], deliver_received, radio_state[2:0],
  // zero fill
  output logic [OutDataW-1:0] m_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  localparam int TW = TagW;

  cfg_t          cfg;
  fifo_ctrl_t    fifo_ctrl;
  fifo_stat_t    fifo_stat;
  logic [TW-1:0] fifo_head, fifo_wdata;

  in_item_t      in_q;
  logic [2:0]    cmd_q;
  logic          in_valid_q;
  res_t          res, out_q;
  logic          out_valid_q;
  logic          fire;

  assign fire     = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      in_q  <= in_item_t'(s_tdata[$bits(in_item_t)-1:0]);
      cmd_q <= s_tuser;
    end
    if (fire) begin
      out_q <= res;
    end
  end

  xmac_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  xmac_tag_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .TW    (TW)
  ) u_tag_fifo (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (fifo_ctrl),
    .wdata_i       (fifo_wdata),
    .queue_limit_i (cfg.queue_limit),
    .stat_o        (fifo_stat),
    .head_o        (fifo_head)
  );

  xmac_core #(
    .TW (TW)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .cmd_i        (cmd_q),
    .item_i       (in_q),
    .cfg_i        (cfg),
    .fifo_stat_i  (fifo_stat),
    .fifo_head_i  (fifo_head),
    .fifo_ctrl_o  (fifo_ctrl),
    .fifo_wdata_o (fifo_wdata),
    .res_o        (res)
  );

  assign m_tvalid = out_valid_q;
  assign m_tdata  = OutDataW'(out_q);

endmodule
